// ===== rtl/rde_pkg.sv =====
package rde_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_READ  = 2'd1,
    JOB_CHECK = 2'd2
  } job_kind_t;

  localparam logic [1:0] REG_NODE_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_SYNC_VALUE     = 2'd1;
  localparam logic [1:0] REG_WRITE_MARKER   = 2'd2;
  localparam logic [1:0] REG_MASTER_ADDRESS = 2'd3;

  localparam logic RES_TX    = 1'b0;
  localparam logic RES_REPLY = 1'b1;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [2:0] STEP_LAST_LONG  = 3'd7;
  localparam logic [2:0] STEP_LAST_SHORT = 3'd3;

  localparam logic [3:0] WINDOW_FULL = 4'd8;

  typedef struct packed {
    job_kind_t   kind;
    logic [63:0] data;
  } job_t;

  typedef struct packed {
    logic busy;
    logic armed;
  } back_status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb = c[7] ^ data[b];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

endpackage

// ===== rtl/rde_front.sv =====
module rde_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        opcode,
  input  logic [6:0]        reg_index,
  input  logic [31:0]       write_word,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output rde_pkg::job_t     push_job,
  input  logic              q_full
);

  logic [7:0] node_address;
  logic [7:0] sync_value;
  logic [7:0] write_marker;
  logic [7:0] master_reply_address;

  logic [7:0] rx_window [8];
  logic [7:0] win_next  [8];
  logic [3:0] window_fill;
  logic [3:0] fill_next;
  logic [6:0] awaited_register;

  logic       accept;
  logic       hdr_ok;
  rde_pkg::op_t op;

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;
  assign op        = rde_pkg::op_t'(opcode);

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      win_next[i] = rx_window[i+1];
    end
    win_next[7] = rx_byte;
    fill_next   = (window_fill == rde_pkg::WINDOW_FULL) ? window_fill : window_fill + 4'd1;
    hdr_ok      = (fill_next == rde_pkg::WINDOW_FULL) &&
                  (win_next[0] == sync_value) &&
                  (win_next[1] == master_reply_address) &&
                  (win_next[2] == {1'b0, awaited_register});
  end

  always_comb begin
    push          = 1'b0;
    push_job.kind = rde_pkg::JOB_CHECK;
    push_job.data = {win_next[0], win_next[1], win_next[2], win_next[3],
                     win_next[4], win_next[5], win_next[6], win_next[7]};
    unique case (op)
      rde_pkg::OP_WRITE: begin
        push          = accept;
        push_job.kind = rde_pkg::JOB_WRITE;
        push_job.data = {sync_value, node_address, {1'b0, reg_index} | write_marker,
                         write_word, 8'h00};
      end
      rde_pkg::OP_READ: begin
        push          = accept;
        push_job.kind = rde_pkg::JOB_READ;
        push_job.data = {sync_value, node_address, {1'b0, reg_index}, 40'h0};
      end
      rde_pkg::OP_RX: begin
        push = accept && hdr_ok;
      end
      rde_pkg::OP_NONE: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address         <= 8'd0;
      sync_value           <= 8'd5;
      write_marker         <= 8'd128;
      master_reply_address <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rde_pkg::REG_NODE_ADDRESS:   node_address         <= cfg_data;
        rde_pkg::REG_SYNC_VALUE:     sync_value           <= cfg_data;
        rde_pkg::REG_WRITE_MARKER:   write_marker         <= cfg_data;
        rde_pkg::REG_MASTER_ADDRESS: master_reply_address <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill      <= 4'd0;
      awaited_register <= 7'd0;
    end else if (accept) begin
      if (op == rde_pkg::OP_READ) begin
        window_fill      <= 4'd0;
        awaited_register <= reg_index;
      end else if (op == rde_pkg::OP_RX) begin
        window_fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == rde_pkg::OP_RX) begin
      for (int i = 0; i < 8; i++) begin
        rx_window[i] <= win_next[i];
      end
    end
  end

endmodule

// ===== rtl/rde_queue.sv =====
module rde_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rde_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rde_pkg::job_t head_job
);

  rde_pkg::job_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/rde_back.sv =====
module rde_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  rde_pkg::job_t        head_job,
  output logic                 pop,
  output rde_pkg::back_status_t status,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic                 result_kind,
  output logic [7:0]           tx_byte,
  output logic [31:0]          reply_word,
  output logic                 last_of_run
);

  logic                busy;
  rde_pkg::job_kind_t  kind;
  logic [63:0]         data;
  logic [2:0]          step;
  logic [7:0]          crc;
  logic                armed;

  logic [63:0] data_sh;
  logic [7:0]  cur_byte;
  logic [2:0]  last_step;
  logic        is_tx;
  logic        match;
  logic        can_emit;
  logic        emit;
  logic        advance;
  logic        finish;

  assign status.busy  = busy;
  assign status.armed = armed;

  always_comb begin
    data_sh   = data << {step, 3'b000};
    cur_byte  = data_sh[63:56];
    last_step = (kind == rde_pkg::JOB_READ) ? rde_pkg::STEP_LAST_SHORT
                                            : rde_pkg::STEP_LAST_LONG;
    is_tx     = (kind != rde_pkg::JOB_CHECK);
    match     = armed && (crc == cur_byte);
    can_emit  = !rsp_valid || rsp_ready;
    if (is_tx) begin
      emit    = busy && can_emit;
      advance = busy && can_emit;
    end else begin
      emit    = busy && (step == rde_pkg::STEP_LAST_LONG) && match && can_emit;
      advance = busy && ((step != rde_pkg::STEP_LAST_LONG) || !match || can_emit);
    end
    finish = advance && (step == last_step);
    pop    = head_valid && (!busy || finish);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      armed <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (pop && head_job.kind == rde_pkg::JOB_READ) begin
        armed <= 1'b1;
      end else if (finish && !is_tx && match) begin
        armed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= head_job.kind;
      data <= head_job.data;
      step <= 3'd0;
      crc  <= 8'h00;
    end else if (advance) begin
      step <= step + 3'd1;
      crc  <= rde_pkg::crc8_byte(crc, cur_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last_of_run <= (step == last_step);
      if (is_tx) begin
        result_kind <= rde_pkg::RES_TX;
        tx_byte     <= (step == last_step) ? crc : cur_byte;
        reply_word  <= 32'h0;
      end else begin
        result_kind <= rde_pkg::RES_REPLY;
        tx_byte     <= 8'h00;
        reply_word  <= data[39:8];
      end
    end
  end

endmodule

// ===== rtl/uart_register_datagram_engine_unit.sv =====
// Master side of a single-wire UART register protocol with CRC-8 (poly 0x07, LSB first,
// init 0). A write item yields 8 transmit bytes, one per cycle unless the output stalls;
// a read item yields 4 transmit bytes and arms the reply search; a received byte is
// shifted into the 8-byte window, and when the window is full and its sync, address and
// register bytes match, the window goes through a check that recomputes the CRC one byte
// per cycle (a matching last byte waits for the output) and yields the reply word on a
// match. The front accepts one item per cycle while its 2-entry job queue has room;
// sustained rate is set by the byte-serial CRC and output stage in the back end, which
// starts a job only when done with the last; bytes that start no check are not queued.
module uart_register_datagram_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  opcode,
  input  logic [6:0]  reg_index,
  input  logic [31:0] write_word,
  input  logic [7:0]  rx_byte,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        result_kind,
  output logic [7:0]  tx_byte,
  output logic [31:0] reply_word,
  output logic        last_of_run
);

  logic                  push;
  rde_pkg::job_t         push_job;
  logic                  q_full;
  logic                  pop;
  logic                  head_valid;
  rde_pkg::job_t         head_job;
  rde_pkg::back_status_t status;

  rde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (opcode),
    .reg_index  (reg_index),
    .write_word (write_word),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_job   (push_job),
    .q_full     (q_full)
  );

  rde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  rde_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .status      (status),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .reply_word  (reply_word),
    .last_of_run (last_of_run)
  );

  a_reply_is_single: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && result_kind == rde_pkg::RES_REPLY) |-> (last_of_run && tx_byte == 8'h00))
    else $error("reply result not a single final item");

  a_tx_has_no_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && result_kind == rde_pkg::RES_TX) |-> (reply_word == 32'h0))
    else $error("transmit result carries a reply word");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !status.busy) |=> status.busy)
    else $error("queued job not taken by idle back end");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("job taken from empty queue");

endmodule

// ===== test/uart_register_datagram_engine_unit_test.sv =====
module uart_register_datagram_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;
  localparam logic [7:0] CRC8_POLY = 8'h07;

  typedef enum {SINK_ALWAYS, SINK_COIN, SINK_PATTERN, SINK_SPARSE} sink_mode_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [31:0] word;
    logic        last;
  } engine_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rde_pkg::REG_NODE_ADDRESS;
  logic [7:0]  cfg_data = 8'h00;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [1:0]  opcode = rde_pkg::OP_NONE;
  logic [6:0]  reg_index = 7'h00;
  logic [31:0] write_word = 32'h0;
  logic [7:0]  rx_byte = 8'h00;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic [31:0] reply_word;
  logic        last_of_run;

  uart_register_datagram_engine_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .opcode      (opcode),
    .reg_index   (reg_index),
    .write_word  (write_word),
    .rx_byte     (rx_byte),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .reply_word  (reply_word),
    .last_of_run (last_of_run)
  );

  // shadow of the engine
  logic [7:0]  cfg_node;
  logic [7:0]  cfg_sync;
  logic [7:0]  cfg_marker;
  logic [7:0]  cfg_master;
  logic [63:0] rx_win;
  logic [3:0]  win_fill;
  logic [6:0]  awaited_reg;
  logic        search_armed;

  engine_result_t due_results[$];
  engine_result_t seen_result;
  engine_result_t want_result;

  int         fails = 0;
  int         cyc = 0;
  int         items_done = 0;
  int         gap_max = 0;
  int         burst_left = 0;
  sink_mode_t sink_mode = SINK_ALWAYS;
  logic       hold_on = 1'b0;
  event       hold_start;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc, due_results.size());
      $display("FAIL uart_register_datagram_engine_unit");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_lsb(input logic [63:0] seq, input int count);
    logic [7:0] crc;
    logic       fb;
    crc = 8'h00;
    for (int i = 0; i < count; i++) begin
      for (int b = 0; b < 8; b++) begin
        fb  = crc[7] ^ seq[8*i+b];
        crc = {crc[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
      end
    end
    return crc;
  endfunction

  task automatic push_due(input logic kind, input logic [7:0] tx, input logic [31:0] word,
                          input logic last);
    engine_result_t r;
    r.kind = kind;
    r.tx   = tx;
    r.word = word;
    r.last = last;
    due_results.push_back(r);
  endtask

  task automatic predict_engine_item(input logic [1:0] op, input logic [6:0] ridx,
                                     input logic [31:0] word, input logic [7:0] rxb);
    logic [63:0] d;
    int          n;
    d = '0;
    n = 0;
    case (op)
      rde_pkg::OP_WRITE: begin
        d[7:0]   = cfg_sync;
        d[15:8]  = cfg_node;
        d[23:16] = {1'b0, ridx} | cfg_marker;
        d[31:24] = word[31:24];
        d[39:32] = word[23:16];
        d[47:40] = word[15:8];
        d[55:48] = word[7:0];
        d[63:56] = crc8_lsb(d, 7);
        n = 8;
      end
      rde_pkg::OP_READ: begin
        d[7:0]   = cfg_sync;
        d[15:8]  = cfg_node;
        d[23:16] = {1'b0, ridx};
        d[31:24] = crc8_lsb(d, 3);
        n = 4;
        rx_win       = '0;
        win_fill     = 4'd0;
        awaited_reg  = ridx;
        search_armed = 1'b1;
      end
      rde_pkg::OP_RX: begin
        rx_win = {rxb, rx_win[63:8]};
        if (win_fill < 4'd8)
          win_fill = win_fill + 4'd1;
        if (search_armed && win_fill == 4'd8 && rx_win[7:0] == cfg_sync &&
            rx_win[15:8] == cfg_master && rx_win[23:16] == {1'b0, awaited_reg} &&
            crc8_lsb(rx_win, 7) == rx_win[63:56]) begin
          search_armed = 1'b0;
          push_due(rde_pkg::RES_REPLY, 8'h00,
                   {rx_win[31:24], rx_win[39:32], rx_win[47:40], rx_win[55:48]}, 1'b1);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++)
      push_due(rde_pkg::RES_TX, d[8*i +: 8], 32'h0, i == n - 1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_node     = 8'd0;
      cfg_sync     = 8'd5;
      cfg_marker   = 8'd128;
      cfg_master   = 8'd255;
      rx_win       = '0;
      win_fill     = 4'd0;
      awaited_reg  = 7'd0;
      search_armed = 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        seen_result.kind = result_kind;
        seen_result.tx   = tx_byte;
        seen_result.word = reply_word;
        seen_result.last = last_of_run;
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected result: kind=%0d tx=%02h word=%08h last=%0d",
                     result_kind, tx_byte, reply_word, last_of_run);
        end else begin
          want_result = due_results.pop_front();
          if (seen_result.kind !== want_result.kind || seen_result.tx !== want_result.tx ||
              seen_result.word !== want_result.word ||
              seen_result.last !== want_result.last) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("mismatch cycle %0d: expected %0d %02h %08h %0d got %0d %02h %08h %0d",
                       cyc, want_result.kind, want_result.tx, want_result.word,
                       want_result.last, seen_result.kind, seen_result.tx,
                       seen_result.word, seen_result.last);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rde_pkg::REG_NODE_ADDRESS: cfg_node   = cfg_data;
          rde_pkg::REG_SYNC_VALUE:   cfg_sync   = cfg_data;
          rde_pkg::REG_WRITE_MARKER: cfg_marker = cfg_data;
          default:                   cfg_master = cfg_data;
        endcase
      end
      if (req_valid && req_ready)
        predict_engine_item(opcode, reg_index, write_word, rx_byte);
    end
  end

  always @(negedge clk) begin
    if (rst || hold_on)
      rsp_ready <= 1'b0;
    else begin
      case (sink_mode)
        SINK_ALWAYS:  rsp_ready <= 1'b1;
        SINK_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
        SINK_PATTERN: rsp_ready <= (cyc % 11) >= 3;
        default:      rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    forever begin
      @(hold_start);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  task automatic send_item(input rde_pkg::op_t op, input logic [6:0] ridx,
                           input logic [31:0] word, input logic [7:0] rxb);
    @(negedge clk);
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        req_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    opcode     = op;
    reg_index  = ridx;
    write_word = word;
    rx_byte    = rxb;
    req_valid  = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (op != rde_pkg::OP_NONE)
      items_done++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item(rde_pkg::OP_RX, 7'($urandom), $urandom, b);
  endtask

  task automatic send_frame(input logic [63:0] f, input int first, input int count);
    for (int i = first; i < first + count; i++)
      send_rx(f[8*i +: 8]);
  endtask

  function automatic logic [63:0] reply_frame(input logic [7:0] reg_byte,
                                              input logic [31:0] data);
    logic [63:0] f;
    f = {8'h00, data[7:0], data[15:8], data[23:16], data[31:24], reg_byte, cfg_master,
         cfg_sync};
    f[63:56] = crc8_lsb(f, 7);
    return f;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // drop valid and wait until the engine has nothing left to deliver
  task automatic settle_engine();
    @(negedge clk);
    req_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_config(input logic [7:0] node, input logic [7:0] sync,
                             input logic [7:0] marker, input logic [7:0] master);
    settle_engine();
    write_register(rde_pkg::REG_NODE_ADDRESS, node);
    write_register(rde_pkg::REG_SYNC_VALUE, sync);
    write_register(rde_pkg::REG_WRITE_MARKER, marker);
    write_register(rde_pkg::REG_MASTER_ADDRESS, master);
  endtask

  task automatic test_reset_defaults();
    gap_max   = 0;
    sink_mode = SINK_ALWAYS;
    send_item(rde_pkg::OP_WRITE, 7'h00, 32'h0000_0000, 8'h00);
    send_item(rde_pkg::OP_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    send_item(rde_pkg::OP_NONE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_special_cases();
    logic [63:0] f;
    sink_mode = SINK_COIN;
    // write in the middle of a reply must not disturb the search
    send_item(rde_pkg::OP_READ, 7'h55, 32'h0, 8'h00);
    f = reply_frame(8'h55, 32'hDEAD_BEEF);
    send_frame(f, 0, 3);
    send_item(rde_pkg::OP_WRITE, 7'h2A, 32'h1234_5678, 8'h00);
    send_frame(f, 3, 5);
    // register byte with its top bit set never matches
    send_item(rde_pkg::OP_READ, 7'h2A, 32'h0, 8'h00);
    send_frame(reply_frame(8'hAA, 32'h0BAD_F00D), 0, 8);
    settle_engine();
  endtask

  task automatic test_backpressure();
    gap_max   = 0;
    sink_mode = SINK_ALWAYS;
    -> hold_start;
    repeat (40) send_item(rde_pkg::OP_WRITE, 7'($urandom), random_word(), 8'($urandom));
    settle_engine();
  endtask

  task automatic random_sequence();
    int          pick;
    logic [6:0]  ridx;
    logic [63:0] f;
    pick = $urandom_range(0, 99);
    ridx = 7'($urandom);
    f    = reply_frame({1'b0, ridx}, random_word());
    if ($urandom_range(0, 29) == 0)
      settle_engine();
    if (pick < 45) begin
      send_item(rde_pkg::OP_READ, ridx, $urandom, 8'($urandom));
      repeat ($urandom_range(0, 3))
        send_rx(($urandom_range(0, 3) == 0) ? cfg_sync : 8'($urandom));
      if ($urandom_range(0, 5) == 0)
        send_item(rde_pkg::OP_WRITE, 7'($urandom), random_word(), 8'($urandom));
      case ($urandom_range(0, 9))
        0: f[63:56] = f[63:56] ^ (8'h01 << $urandom_range(0, 7));
        1: f = reply_frame({1'b1, ridx}, f[55:24]);
        2: begin
          f[15:0]  = f[15:0] ^ (16'h0001 << $urandom_range(0, 15));
          f[63:56] = crc8_lsb(f, 7);
        end
        3: begin
          send_frame(f, 0, $urandom_range(1, 7));
          send_item(rde_pkg::OP_READ, ridx, $urandom, 8'($urandom));
        end
        default: ;
      endcase
      send_frame(f, 0, 8);
    end else if (pick < 70)
      send_item(rde_pkg::OP_WRITE, ridx, random_word(), 8'($urandom));
    else if (pick < 85)
      repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
    else if (pick < 90)
      send_item(rde_pkg::OP_NONE, 7'($urandom), $urandom, 8'($urandom));
    else
      send_frame(f, 0, 8);
  endtask

  task automatic random_phase(input int quota);
    int target;
    target = items_done + quota;
    while (items_done < target)
      random_sequence();
  endtask

  task automatic test_random_traffic();
    load_config(8'd0, 8'd5, 8'd128, 8'd255);
    gap_max   = 4;
    sink_mode = SINK_COIN;
    random_phase(90);

    load_config(8'h00, 8'h00, 8'h00, 8'h00);
    gap_max   = 0;
    sink_mode = SINK_ALWAYS;
    random_phase(90);

    load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    gap_max   = 8;
    sink_mode = SINK_SPARSE;
    random_phase(90);

    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    gap_max   = 2;
    sink_mode = SINK_PATTERN;
    random_phase(90);

    load_config(8'($urandom), 8'($urandom), 8'h80 >> $urandom_range(0, 7), 8'($urandom));
    gap_max   = 6;
    sink_mode = SINK_COIN;
    random_phase(90);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_special_cases();
    test_backpressure();
    test_random_traffic();
    settle_engine();
    if (fails == 0 && due_results.size() == 0)
      $display("PASS uart_register_datagram_engine_unit");
    else
      $display("FAIL uart_register_datagram_engine_unit");
    $finish;
  end

endmodule
